### hdl/vbra_pkg.sv
// ----------------------------------------------------------------------------
// vbra_pkg
// shared types and constants of the variable block ring allocator
// ----------------------------------------------------------------------------
package vbra_pkg;

    localparam int OFFSET_W = 16;
    localparam int SIZE_W   = 17;
    localparam int STAMP_W  = 32;
    localparam int OP_W     = 3;

    // operation codes carried on the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 3'd0,
        OP_COMMIT  = 3'd1,
        OP_PEEK    = 3'd2,
        OP_RELEASE = 3'd3,
        OP_COUNT   = 3'd4,
        OP_CLEAR   = 3'd5
    } t_op;

    // one block descriptor as kept in the descriptor memory
    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [SIZE_W-1:0]   size;
        logic [OFFSET_W-1:0] offset;
    } t_desc;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // input transaction taken, latch it and start reads
        logic finish;    // result goes to the output register, state updates
    } t_ctrl_cmd;

endpackage

### hdl/vbra_ram.sv
// ----------------------------------------------------------------------------
// vbra_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module vbra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### hdl/vbra_ctrl.sv
// ----------------------------------------------------------------------------
// vbra_ctrl
// controller: accepts one transaction, waits for read data and a free output
// ----------------------------------------------------------------------------
module vbra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vbra_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_cmd.capture = 1'b0;
        o_cmd.finish  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // read data is ready here, wait only for the output slot
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/vbra_dp.sv
// ----------------------------------------------------------------------------
// vbra_dp
// datapath: descriptor memory, fifo pointers, ring size and result register
// ----------------------------------------------------------------------------
module vbra_dp #(
    parameter int DESCRIPTOR_DEPTH = 1024,
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  vbra_pkg::t_ctrl_cmd                    i_cmd,
    input  logic                                   i_cfg_wr,
    input  logic [vbra_pkg::SIZE_W-1:0]            i_cfg_data,
    input  logic [vbra_pkg::OP_W-1:0]              i_op,
    input  logic [vbra_pkg::OFFSET_W-1:0]          i_offset,
    input  logic [vbra_pkg::SIZE_W-1:0]            i_size,
    input  logic [vbra_pkg::STAMP_W-1:0]           i_stamp,
    output logic                                   o_status,
    output logic [vbra_pkg::OFFSET_W-1:0]          o_found_offset,
    output logic [vbra_pkg::SIZE_W-1:0]            o_found_size,
    output logic [vbra_pkg::STAMP_W-1:0]           o_stamp_gap,
    output logic [$clog2(DESCRIPTOR_DEPTH+1)-1:0]  o_block_count
);

    localparam int PTR_W   = $clog2(DESCRIPTOR_DEPTH);
    localparam int CNT_W   = $clog2(DESCRIPTOR_DEPTH + 1);
    localparam int SIZE_W  = vbra_pkg::SIZE_W;
    localparam int OFF_W   = vbra_pkg::OFFSET_W;
    localparam int SIZE_MAX_VAL = (1 << SIZE_W) - 1;
    localparam int RING_CAP = (MAX_BUFFER_BYTES > SIZE_MAX_VAL) ? SIZE_MAX_VAL
                                                                : MAX_BUFFER_BYTES;
    localparam int RING_RST = (RING_CAP < 65536) ? RING_CAP : 65536;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DESCRIPTOR_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DESCRIPTOR_DEPTH);
    localparam logic [SIZE_W-1:0] CAP_BYTES = SIZE_W'(RING_CAP);

    vbra_pkg::t_op        r_op;
    logic [OFF_W-1:0]     r_offset;
    logic [SIZE_W-1:0]    r_size;
    logic [vbra_pkg::STAMP_W-1:0] r_stamp;

    logic [PTR_W-1:0]     r_oldest, n_oldest;
    logic [PTR_W-1:0]     r_newest, n_newest;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SIZE_W-1:0]    r_ring;

    logic                 r_status, n_status;
    logic [OFF_W-1:0]     r_foff, n_foff;
    logic [SIZE_W-1:0]    r_fsize, n_fsize;
    logic [vbra_pkg::STAMP_W-1:0] r_gap, n_gap;

    logic [PTR_W-1:0]     oldest_next;
    logic [PTR_W-1:0]     newest_next;
    logic [PTR_W-1:0]     newest_prev;
    logic [PTR_W-1:0]     rd_addr_b;
    vbra_pkg::t_desc      rd_a;
    vbra_pkg::t_desc      rd_b;
    vbra_pkg::t_desc      wr_desc;
    logic                 wr_en;

    logic                 size_ok;
    logic [SIZE_W-1:0]    head;
    logic [SIZE_W:0]      prop;
    logic [SIZE_W+1:0]    prop_end;

    assign oldest_next = (r_oldest == PTR_LAST) ? '0 : r_oldest + 1'b1;
    assign newest_next = (r_newest == PTR_LAST) ? '0 : r_newest + 1'b1;
    assign newest_prev = (r_newest == '0) ? PTR_LAST : r_newest - 1'b1;

    // port a always reads the oldest block, port b the second oldest for a
    // peek and the newest block otherwise
    assign rd_addr_b = (vbra_pkg::t_op'(i_op) == vbra_pkg::OP_PEEK) ? oldest_next
                                                                     : newest_prev;

    assign wr_desc.offset = r_offset;
    assign wr_desc.size   = r_size;
    assign wr_desc.stamp  = r_stamp;

    vbra_ram #(
        .WIDTH ($bits(vbra_pkg::t_desc)),
        .DEPTH (DESCRIPTOR_DEPTH)
    ) u_desc_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_newest),
        .i_wr_data   (wr_desc),
        .i_rd_en     (i_cmd.capture),
        .i_rd_addr_a (r_oldest),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign size_ok  = (r_size != '0) && (r_size <= r_ring);
    assign head     = {1'b0, rd_a.offset};
    assign prop     = {2'b00, rd_b.offset} + {1'b0, rd_b.size};
    assign prop_end = {1'b0, prop} + {2'b00, r_size};

    always_comb begin
        n_status = 1'b0;
        n_foff   = '0;
        n_fsize  = '0;
        n_gap    = '0;
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_count  = r_count;
        wr_en    = 1'b0;
        case (r_op)
            vbra_pkg::OP_RESERVE: begin
                if (!size_ok) begin
                    n_status = 1'b1;
                end else if (r_count != '0) begin
                    if (prop_end <= {2'b00, r_ring}) begin
                        // fits before the end of the ring
                        if (({1'b0, head} >= prop) && (prop_end > {2'b00, head})) begin
                            n_status = 1'b1;
                        end else begin
                            n_foff = prop[OFF_W-1:0];
                        end
                    end else if ({1'b0, head} >= prop) begin
                        n_status = 1'b1;
                    end else if (r_size > head) begin
                        // wrapped to the start but runs into the oldest block
                        n_status = 1'b1;
                    end
                end
            end
            vbra_pkg::OP_COMMIT: begin
                if (!size_ok || (r_count == CNT_FULL)) begin
                    n_status = 1'b1;
                end else begin
                    wr_en    = i_cmd.finish;
                    n_newest = newest_next;
                    n_count  = r_count + 1'b1;
                end
            end
            vbra_pkg::OP_PEEK: begin
                if (r_count < CNT_W'(2)) begin
                    n_status = 1'b1;
                end else begin
                    n_foff  = rd_a.offset;
                    n_fsize = rd_a.size;
                    n_gap   = rd_b.stamp - rd_a.stamp;
                end
            end
            vbra_pkg::OP_RELEASE: begin
                if (r_count == '0) begin
                    n_status = 1'b1;
                end else begin
                    n_oldest = oldest_next;
                    n_count  = r_count - 1'b1;
                end
            end
            vbra_pkg::OP_COUNT: begin
                n_status = 1'b0;
            end
            vbra_pkg::OP_CLEAR: begin
                n_oldest = '0;
                n_newest = '0;
                n_count  = '0;
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
    end

    // latched transaction and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= vbra_pkg::t_op'(i_op);
            r_offset <= i_offset;
            r_size   <= i_size;
            r_stamp  <= i_stamp;
        end
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_foff   <= n_foff;
            r_fsize  <= n_fsize;
            r_gap    <= n_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_newest <= '0;
            r_count  <= '0;
            r_ring   <= SIZE_W'(RING_RST);
        end else begin
            if (i_cmd.finish) begin
                r_oldest <= n_oldest;
                r_newest <= n_newest;
                r_count  <= n_count;
            end
            if (i_cfg_wr) begin
                r_ring <= (i_cfg_data > CAP_BYTES) ? CAP_BYTES : i_cfg_data;
            end
        end
    end

    assign o_status       = r_status;
    assign o_found_offset = r_foff;
    assign o_found_size   = r_fsize;
    assign o_stamp_gap    = r_gap;
    // the count only moves on finish, so it matches the held result
    assign o_block_count  = r_count;

endmodule

### hdl/variable_block_ring_allocator.sv
// ----------------------------------------------------------------------------
// variable_block_ring_allocator
// ring buffer allocator keeping a fifo of block descriptors (offset, size,
// time stamp) for a byte ring, with reserve, commit, peek, release, count
// and clear
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: operation
//                                                      tdata: offset, size, stamp
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: status, offset,
//                                                      size, gap, count
//  cfg       in         i_cfg_valid / o_cfg_ready      ring size in bytes
//
//  each transaction: the accept edge launches both descriptor memory
//  reads, and exec loads the result register once the output slot is free
//  one operation is in flight at a time; the next one is taken while the
//  result still waits on m_axis, and exec holds while the result is stalled
//  reset (synchronous, active low) empties the fifo and sets the ring size
//  to 65536 bytes, limited to MAX_BUFFER_BYTES; descriptor memory is not
//  cleared, only live entries are ever read
//
module variable_block_ring_allocator #(
    parameter int DESCRIPTOR_DEPTH = 1024,
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,      // buffer_bytes

    // operation stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,    // block_offset, block_size, time_stamp, pad
    input  logic [2:0]  s_axis_tuser,    // operation

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, found_offset, found_size, stamp_gap, block_count, pad
    output logic [((66 + $clog2(DESCRIPTOR_DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int CNT_W    = $clog2(DESCRIPTOR_DEPTH + 1);
    localparam int RES_BITS = 66 + CNT_W;
    localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

    vbra_pkg::t_ctrl_cmd cmd;

    logic                          status;
    logic [vbra_pkg::OFFSET_W-1:0] found_offset;
    logic [vbra_pkg::SIZE_W-1:0]   found_size;
    logic [vbra_pkg::STAMP_W-1:0]  stamp_gap;
    logic [CNT_W-1:0]              block_count;

    // ring size is a plain register, always ready
    assign o_cfg_ready = 1'b1;

    vbra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    vbra_dp #(
        .DESCRIPTOR_DEPTH (DESCRIPTOR_DEPTH),
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_wr       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_op           (s_axis_tuser),
        .i_offset       (s_axis_tdata[15:0]),
        .i_size         (s_axis_tdata[32:16]),
        .i_stamp        (s_axis_tdata[64:33]),
        .o_status       (status),
        .o_found_offset (found_offset),
        .o_found_size   (found_size),
        .o_stamp_gap    (stamp_gap),
        .o_block_count  (block_count)
    );

    // pack the result fields from bit 0 up, zero filled to whole bytes
    assign m_axis_tdata = OUT_W'({block_count, stamp_gap, found_size, found_offset, status});

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the variable block ring allocator: directed corner
// operations, then random well-formed reserve/commit traffic mixed with
// releases, peeks and noise, across several ring sizes, checked against an
// in-bench descriptor fifo model
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH     = 1024;
    localparam int MAX_BYTES = 65536;
    localparam int RES_BITS  = 66 + $clog2(DEPTH + 1);
    localparam int RES_W     = ((RES_BITS + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [vbra_pkg::OFFSET_W-1:0] t_offset;
    typedef logic [vbra_pkg::SIZE_W-1:0]   t_size;
    typedef logic [vbra_pkg::STAMP_W-1:0]  t_stamp;

    // codes outside the defined operation set
    localparam logic [vbra_pkg::OP_W-1:0] OP_UNDEF_6 = 3'd6;
    localparam logic [vbra_pkg::OP_W-1:0] OP_UNDEF_7 = 3'd7;

    // result fields, last declared field (status) in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic [10:0] block_count;
        t_stamp      stamp_gap;
        t_size       found_size;
        t_offset     found_offset;
        logic        status;
    } t_alloc_res;

    class alloc_scoreboard;
        t_offset offset_mem [DEPTH];
        t_size   size_mem   [DEPTH];
        t_stamp  stamp_mem  [DEPTH];
        int unsigned head_ptr, tail_ptr, live, ring_bytes;
        t_alloc_res  expected_q [$];
        int mismatches, checked, peak_live, full_rejects;

        function new();
            head_ptr = 0;
            tail_ptr = 0;
            live = 0;
            ring_bytes = MAX_BYTES;
            mismatches = 0;
            checked = 0;
            peak_live = 0;
            full_rejects = 0;
        endfunction

        function void set_ring(t_size v);
            ring_bytes = (v > MAX_BYTES) ? MAX_BYTES : v;
        endfunction

        function bit size_fits(t_size sz);
            return sz != 0 && sz <= ring_bytes;
        endfunction

        // reserve leaves the state alone, so the driver may look ahead
        function t_alloc_res try_reserve(t_size sz);
            t_alloc_res  r;
            int unsigned last, start, head_off;
            r = '0;
            if (!size_fits(sz)) begin
                r.status = 1'b1;
            end else if (live != 0) begin
                last = (tail_ptr == 0) ? DEPTH - 1 : tail_ptr - 1;
                head_off = offset_mem[head_ptr];
                start = offset_mem[last] + size_mem[last];
                if (start + sz <= ring_bytes) begin
                    if (head_off >= start && start + sz > head_off) r.status = 1'b1;
                end else if (head_off >= start) begin
                    r.status = 1'b1;
                end else begin
                    // wrap to the start of the ring
                    start = 0;
                    if (sz > head_off) r.status = 1'b1;
                end
                if (!r.status) r.found_offset = start[vbra_pkg::OFFSET_W-1:0];
            end
            r.block_count = live[10:0];
            return r;
        endfunction

        function void note_op(logic [vbra_pkg::OP_W-1:0] op, vbra_pkg::t_desc d);
            t_alloc_res r;
            r = '0;
            case (op)
                vbra_pkg::OP_RESERVE: r = try_reserve(d.size);
                vbra_pkg::OP_COMMIT: begin
                    if (!size_fits(d.size) || live >= DEPTH) begin
                        r.status = 1'b1;
                        if (live >= DEPTH) full_rejects++;
                    end else begin
                        offset_mem[tail_ptr] = d.offset;
                        size_mem[tail_ptr]   = d.size;
                        stamp_mem[tail_ptr]  = d.stamp;
                        tail_ptr = (tail_ptr + 1) % DEPTH;
                        live++;
                        if (live > peak_live) peak_live = live;
                    end
                end
                vbra_pkg::OP_PEEK: begin
                    if (live < 2) begin
                        r.status = 1'b1;
                    end else begin
                        r.found_offset = offset_mem[head_ptr];
                        r.found_size   = size_mem[head_ptr];
                        r.stamp_gap    = stamp_mem[(head_ptr + 1) % DEPTH]
                                         - stamp_mem[head_ptr];
                    end
                end
                vbra_pkg::OP_RELEASE: begin
                    if (live == 0) begin
                        r.status = 1'b1;
                    end else begin
                        head_ptr = (head_ptr + 1) % DEPTH;
                        live--;
                    end
                end
                vbra_pkg::OP_COUNT: ;
                vbra_pkg::OP_CLEAR: begin
                    head_ptr = 0;
                    tail_ptr = 0;
                    live = 0;
                end
                default: r.status = 1'b1;
            endcase
            r.block_count = live[10:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [RES_BITS-1:0] data);
            t_alloc_res got, want;
            got = t_alloc_res'(data);
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", data);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.found_offset !== want.found_offset
                || got.found_size !== want.found_size || got.stamp_gap !== want.stamp_gap
                || got.block_count !== want.block_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch #%0d: exp st=%0d off=%h size=%h gap=%h cnt=%0d",
                             checked, want.status, want.found_offset, want.found_size,
                             want.stamp_gap, want.block_count);
                    $display("    got st=%0d off=%h size=%h gap=%h cnt=%0d",
                             got.status, got.found_offset, got.found_size,
                             got.stamp_gap, got.block_count);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    t_size                        i_cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [71:0]                  s_axis_tdata;
    logic [vbra_pkg::OP_W-1:0]    s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [RES_W-1:0]             m_axis_tdata;

    alloc_scoreboard sb;
    bit steady;       // both sides stop idling while set
    bit hold_req;     // asks the receiver for one long hold-off
    bit hold_done;
    int ops_sent;
    int cfg_writes;

    always #1 i_clk = ~i_clk;

    variable_block_ring_allocator #(
        .DESCRIPTOR_DEPTH(DEPTH),
        .MAX_BUFFER_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[RES_BITS-1:0]);
    end

    // receiver: random backpressure plus one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic t_offset rand_off();
        return t_offset'($urandom_range(0, 65535));
    endfunction

    function automatic t_size rand_size();
        return t_size'($urandom_range(0, MAX_BYTES));
    endfunction

    task automatic send_op(logic [vbra_pkg::OP_W-1:0] op, t_offset off,
                           t_size sz, t_stamp stamp);
        while (!steady && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, stamp, sz, off};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_op(op, vbra_pkg::t_desc'{stamp: stamp, size: sz, offset: off});
        ops_sent++;
    endtask

    // drop valid, let every expected result come back, then a short pause
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring(t_size v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_ring(v);
        cfg_writes++;
    endtask

    function automatic t_size pick_size(int unsigned ring);
        int unsigned r, top, v;
        r = $urandom_range(99);
        top = (ring / 6 > 1) ? ring / 6 : 1;
        if (r < 4) v = 0;
        else if (r < 8) v = MAX_BYTES;
        else if (r < 12) v = (ring < MAX_BYTES) ? ring + 1 : $urandom_range(1, MAX_BYTES);
        else if (r < 18) v = (ring == 0) ? 1 : ring;
        else if (r < 24) v = $urandom_range(1, MAX_BYTES);
        else v = $urandom_range(1, top);
        return t_size'(v);
    endfunction

    task automatic random_phase(int n);
        int unsigned   kind;
        int            start_ops;
        t_size         sz;
        t_alloc_res    peek_res;
        start_ops = ops_sent;
        while (ops_sent - start_ops < n) begin
            if (!hold_req && ops_sent > 50) hold_req = 1'b1;
            kind = $urandom_range(99);
            if (kind < 45) begin
                // well-formed pair: reserve, then commit where it was proposed
                sz = pick_size(sb.ring_bytes);
                peek_res = sb.try_reserve(sz);
                send_op(vbra_pkg::OP_RESERVE, rand_off(), sz, $urandom());
                if (!peek_res.status && $urandom_range(99) < 85)
                    send_op(vbra_pkg::OP_COMMIT, peek_res.found_offset, sz, $urandom());
            end else if (kind < 65) begin
                send_op(vbra_pkg::OP_RELEASE, rand_off(), rand_size(), $urandom());
            end else if (kind < 77) begin
                send_op(vbra_pkg::OP_PEEK, rand_off(), rand_size(), $urandom());
            end else if (kind < 82) begin
                send_op(vbra_pkg::OP_COUNT, rand_off(), rand_size(), $urandom());
            end else if (kind < 84) begin
                send_op(vbra_pkg::OP_CLEAR, rand_off(), rand_size(), $urandom());
            end else if (kind < 86) begin
                send_op(($urandom_range(1) != 0) ? OP_UNDEF_6 : OP_UNDEF_7,
                        rand_off(), rand_size(), $urandom());
            end else begin
                // raw commit with an arbitrary offset
                send_op(vbra_pkg::OP_COMMIT, rand_off(), pick_size(sb.ring_bytes),
                        $urandom());
            end
        end
    endtask

    // fill the descriptor fifo to the top, then refill across the tail wrap
    task automatic fill_and_wrap();
        steady = 1'b1;
        send_op(vbra_pkg::OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < DEPTH + 2; i++)
            send_op(vbra_pkg::OP_COMMIT, i[vbra_pkg::OFFSET_W-1:0], 17'd1, $urandom());
        send_op(vbra_pkg::OP_PEEK, '0, '0, '0);
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd1, '0);
        for (int i = 0; i < 3; i++)
            send_op(vbra_pkg::OP_RELEASE, '0, '0, '0);
        send_op(vbra_pkg::OP_COMMIT, 16'd2000, 17'd16, $urandom());
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd8, '0);
        send_op(vbra_pkg::OP_PEEK, '0, '0, '0);
        send_op(vbra_pkg::OP_RELEASE, '0, '0, '0);
        steady = 1'b0;
    endtask

    initial begin
        sb = new();
        steady = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        ops_sent = 0;
        cfg_writes = 0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= vbra_pkg::OP_COUNT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset ring size
        send_op(vbra_pkg::OP_COUNT, '0, '0, '0);
        send_op(vbra_pkg::OP_PEEK, '0, '0, '0);                  // too few blocks
        send_op(vbra_pkg::OP_RELEASE, '0, '0, '0);               // empty fifo
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd0, '0);            // bad size
        send_op(vbra_pkg::OP_RESERVE, 16'hffff, 17'd65536, '0);  // empty fifo proposes 0
        send_op(vbra_pkg::OP_COMMIT, 16'd0, 17'd65536, 32'h7fffffff);
        send_op(vbra_pkg::OP_PEEK, '0, '0, '0);                  // only one block
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd1, '0);            // ring taken
        send_op(vbra_pkg::OP_RELEASE, '0, '0, '0);
        send_op(vbra_pkg::OP_COMMIT, 16'd0, 17'd100, 32'h80000000);
        send_op(vbra_pkg::OP_COMMIT, 16'd100, 17'd200, 32'h7fffffff);
        send_op(vbra_pkg::OP_PEEK, '0, '0, '0);                  // gap wraps negative
        send_op(vbra_pkg::OP_RELEASE, '0, '0, '0);
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd65236, '0);        // fits exactly to the end
        send_op(vbra_pkg::OP_COMMIT, 16'd65000, 17'd500, '0);
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd50, '0);           // wraps to 0
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd101, '0);          // wraps into the head
        send_op(vbra_pkg::OP_CLEAR, '0, '0, '0);
        send_op(vbra_pkg::OP_COMMIT, 16'd1000, 17'd10, '0);
        send_op(vbra_pkg::OP_COMMIT, 16'd0, 17'd500, 32'd5);
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd600, '0);          // runs into the head
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd500, '0);          // ends right at the head
        send_op(vbra_pkg::OP_RESERVE, '0, 17'd65100, '0);        // past the end, head ahead
        send_op(vbra_pkg::OP_PEEK, '0, '0, '0);
        send_op(OP_UNDEF_6, 16'hffff, 17'h1ffff, 32'hffffffff);
        send_op(OP_UNDEF_7, '0, '0, '0);

        // random part over several ring sizes
        write_ring(17'd4096);
        random_phase(80);
        write_ring(17'd1);
        random_phase(20);
        write_ring(17'd0);                                       // every size is bad
        random_phase(20);
        write_ring(17'h1ffff);                                   // clipped to the maximum
        random_phase(40);
        write_ring(17'd300);
        random_phase(40);
        write_ring(t_size'($urandom_range(1, MAX_BYTES)));
        random_phase(40);
        write_ring(17'd65536);
        fill_and_wrap();
        random_phase(30);

        wait_drained();
        $display("sent %0d operations over %0d ring size writes, checked %0d results",
                 ops_sent, cfg_writes, sb.checked);
        $display("fifo peaked at %0d blocks, %0d commits refused when full",
                 sb.peak_live, sb.full_rejects);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
